// ===== rtl/core/lane_steering_mode_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Lane steering mode controller assertion macros
// Clocked assertion wrappers shared by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef LANE_STEERING_MODE_CONTROLLER_TOP_MACROS_SVH
`define LANE_STEERING_MODE_CONTROLLER_TOP_MACROS_SVH

// Checked on clk, off while arst_n is low.
`define LSMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on clk, reset included.
`define LSMC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Lane steering mode controller package
// Payload types, register map and command arithmetic.
// ----------------------------------------------------------------------------
package lsmc_pkg;

	localparam int unsigned DIR_W   = 12;
	localparam int unsigned CMD_W   = 8;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned PDATA_W = 32;

	// Register index taken from paddr[2]
	localparam logic REG_DESCENT_CODE = 1'b0;
	localparam logic REG_CRUISE_CODE  = 1'b1;

	localparam logic [CMD_W-1:0] BASE_RIGHT    = 8'd50;
	localparam logic [CMD_W-1:0] BASE_STRAIGHT = 8'd75;
	localparam logic [CMD_W-1:0] BASE_LEFT     = 8'd100;
	localparam logic [DIR_W-1:0] DIR_CENTER    = 12'd1500;
	localparam logic [CMD_W-1:0] CMD_RIGHT_BIT = 8'h80;

	typedef struct packed {
		logic [DIR_W-1:0] direction;
		logic             departed_left;
		logic             departed_right;
		logic             forward_path;
		logic             right_turn_seen;
		logic             left_turn_seen;
		logic             left_line_seen;
		logic             right_line_seen;
		logic             downhill_seen;
		logic             downhill_confirm;
		logic             road_close;
		logic [CMD_W-1:0] previous_command;
	} frame_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             mode_going;
		logic             mode_left;
		logic             mode_right;
		logic             mode_curve;
	} result_t;

	// direction/20 = (direction>>2)/5; x*205>>10 is exact for x < 1024
	function automatic logic [CMD_W-1:0] dir_base(input logic [DIR_W-1:0] dir);
		logic [17:0] prod;
		prod = {8'd0, dir[DIR_W-1:2]} * 18'd205;
		return prod[17:10];
	endfunction

	function automatic logic [CMD_W-1:0] add_speed(
		input logic [CMD_W-1:0] base,
		input logic             use_slow,
		input logic [CMD_W-1:0] slow,
		input logic [CMD_W-1:0] normal
	);
		return base + (use_slow ? slow : normal);
	endfunction

endpackage

// ===== rtl/core/lsmc_if.sv =====
// ----------------------------------------------------------------------------
// Lane steering mode controller channels
// Valid/ready channels for input frames and command results.
// ----------------------------------------------------------------------------
interface lsmc_frame_if import lsmc_pkg::*; ();
	logic   valid;
	logic   ready;
	frame_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lsmc_result_if import lsmc_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lane_steering_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// Lane steering mode controller
// Turns vision frame flags into a steering-plus-speed command byte.
// ----------------------------------------------------------------------------
// One frame per clock unless the result stalls. A frame is captured into an
// input register, the ordered mode rules and the command sum are evaluated
// from it against the four mode flags, and the command plus updated flags
// land in the result register; the flags update on that same edge, so each
// frame sees the flags left by the frame before it. A result passes both
// registers before it is valid. While the result is stalled the result
// register holds and the input register takes a frame only while empty.
// The descent speed code sits at byte address 0 and the cruise speed code
// at address 4; write them only when the block is idle.
`include "lane_steering_mode_controller_top_macros.svh"

module lane_steering_mode_controller_top
	import lsmc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	lsmc_frame_if.sink          frame,
	lsmc_result_if.source       result
);

	logic [CMD_W-1:0] descent_code_q;
	logic [CMD_W-1:0] cruise_code_q;

	logic   valid_s1;
	frame_t frame_s1;
	logic   out_valid_q;
	result_t out_q;

	logic going_q, left_q, right_q, curve_q;
	logic go_d, left_d, right_d, curve_d;
	logic [CMD_W-1:0] cmd_d;

	logic out_free;
	logic adv;
	logic cfg_wr;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descent_code_q <= '0;
			cruise_code_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DESCENT_CODE: descent_code_q <= pwdata[CMD_W-1:0];
				REG_CRUISE_CODE:  cruise_code_q  <= pwdata[CMD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DESCENT_CODE: prdata = {{(PDATA_W-CMD_W){1'b0}}, descent_code_q};
			REG_CRUISE_CODE:  prdata = {{(PDATA_W-CMD_W){1'b0}}, cruise_code_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign out_free    = !out_valid_q || result.ready;
	assign adv         = valid_s1 && out_free;
	assign frame.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			frame_s1 <= frame.data;
		end
	end

	// ---------------- mode rules ----------------
	always_comb begin
		logic             done;
		logic             line;
		logic [CMD_W-1:0] buf_v;
		logic [CMD_W-1:0] dbase;

		go_d    = going_q;
		left_d  = left_q;
		right_d = right_q;
		curve_d = curve_q;
		done    = 1'b0;
		buf_v   = frame_s1.previous_command;
		dbase   = dir_base(frame_s1.direction);
		line    = frame_s1.left_line_seen || frame_s1.right_line_seen;
		cmd_d   = buf_v;

		if (frame_s1.departed_left) begin
			go_d    = 1'b0;
			right_d = 1'b1;
			cmd_d   = add_speed(BASE_RIGHT, frame_s1.downhill_seen,
				descent_code_q, cruise_code_q);
			done    = 1'b1;
		end else if (frame_s1.departed_right) begin
			go_d   = 1'b0;
			left_d = 1'b1;
			cmd_d  = add_speed(BASE_LEFT, frame_s1.downhill_seen && right_d,
				descent_code_q, cruise_code_q);
			done   = 1'b1;
		end else begin
			if (go_d) begin
				if (!frame_s1.forward_path &&
					(frame_s1.right_turn_seen || frame_s1.left_turn_seen)) begin
					go_d    = 1'b0;
					curve_d = 1'b1;
					cmd_d   = buf_v;
					done    = 1'b1;
				end else if (!(right_d || left_d)) begin
					cmd_d = add_speed(dbase, 1'b0, descent_code_q, cruise_code_q);
					done  = 1'b1;
				end
			end
			if (!done && right_d) begin
				if (!line) begin
					left_d  = 1'b0;
					right_d = 1'b0;
					go_d    = 1'b1;
					cmd_d   = buf_v;
					done    = 1'b1;
				end else if (frame_s1.downhill_seen && frame_s1.downhill_confirm) begin
					cmd_d = add_speed(dbase, 1'b1, descent_code_q, cruise_code_q);
					done  = 1'b1;
				end else begin
					// fall through to the later rules with bit 7 forced
					buf_v = buf_v | CMD_RIGHT_BIT;
				end
			end
			if (!done && left_d) begin
				if (!line) begin
					left_d  = 1'b0;
					right_d = 1'b0;
					go_d    = 1'b1;
				end
				cmd_d = buf_v;
				done  = 1'b1;
			end
			if (!done && curve_d) begin
				if (frame_s1.road_close) begin
					if (frame_s1.direction < DIR_CENTER) begin
						curve_d = 1'b0;
						right_d = 1'b1;
						cmd_d   = add_speed(BASE_RIGHT, frame_s1.downhill_seen,
							descent_code_q, cruise_code_q);
					end else if (frame_s1.direction > DIR_CENTER) begin
						curve_d = 1'b0;
						left_d  = 1'b1;
						cmd_d   = add_speed(BASE_LEFT, frame_s1.downhill_seen && right_d,
							descent_code_q, cruise_code_q);
					end else begin
						cmd_d = add_speed(dbase, frame_s1.downhill_seen && right_d,
							descent_code_q, cruise_code_q);
					end
				end else begin
					cmd_d = add_speed(BASE_STRAIGHT, frame_s1.downhill_seen && right_d,
						descent_code_q, cruise_code_q);
				end
				done = 1'b1;
			end
			if (!done) begin
				cmd_d = buf_v;
			end
		end
	end

	// Flags advance together with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			going_q <= 1'b1;
			left_q  <= 1'b0;
			right_q <= 1'b0;
			curve_q <= 1'b0;
		end else if (adv) begin
			going_q <= go_d;
			left_q  <= left_d;
			right_q <= right_d;
			curve_q <= curve_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.command    <= cmd_d;
			out_q.mode_going <= go_d;
			out_q.mode_left  <= left_d;
			out_q.mode_right <= right_d;
			out_q.mode_curve <= curve_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// ---------------- assertions ----------------
	`LSMC_ASSERT(a_result_from_stage, $rose(out_valid_q) |-> $past(valid_s1), "result without a staged frame")
	`LSMC_ASSERT(a_flags_hold, !adv |=> $stable({going_q, left_q, right_q, curve_q}), "mode flags moved without a transaction")
	`LSMC_ASSERT(a_flags_match, out_valid_q |-> (out_q.mode_going == going_q && out_q.mode_left == left_q && out_q.mode_right == right_q && out_q.mode_curve == curve_q), "result flags differ from mode state")
	`LSMC_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

// ===== dv/lane_steering_mode_controller_top_tb.sv =====
// ----------------------------------------------------------------------------
// Lane steering mode controller testbench
// Drives vision frames through the valid/ready channel and writes the speed
// codes over APB. A scoreboard tracks the four mode flags, predicts each
// command byte and compares every returned result field by field.
// ----------------------------------------------------------------------------
module lane_steering_mode_controller_top_tb import lsmc_pkg::*; ();

	localparam int unsigned PHASES       = 6;
	localparam int unsigned RANDOM_ITEMS = 1740;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	// Flag bits in frame order, departed_left first, road_close last
	localparam logic [9:0] FL_DEP_L  = 10'b10_0000_0000;
	localparam logic [9:0] FL_DEP_R  = 10'b01_0000_0000;
	localparam logic [9:0] FL_FWD    = 10'b00_1000_0000;
	localparam logic [9:0] FL_RTURN  = 10'b00_0100_0000;
	localparam logic [9:0] FL_LTURN  = 10'b00_0010_0000;
	localparam logic [9:0] FL_LLINE  = 10'b00_0001_0000;
	localparam logic [9:0] FL_RLINE  = 10'b00_0000_1000;
	localparam logic [9:0] FL_DOWN1  = 10'b00_0000_0100;
	localparam logic [9:0] FL_DOWN2  = 10'b00_0000_0010;
	localparam logic [9:0] FL_CLOSE  = 10'b00_0000_0001;

	class steering_scoreboard;
		logic [CMD_W-1:0] slow_code;
		logic [CMD_W-1:0] normal_code;
		bit going;
		bit turn_left;
		bit turn_right;
		bit curve;
		result_t pending_cmds[$];
		int unsigned mismatches;

		function new();
			slow_code = '0;
			normal_code = '0;
			going = 1'b1;
			turn_left = 1'b0;
			turn_right = 1'b0;
			curve = 1'b0;
			mismatches = 0;
		endfunction

		function void set_speed(logic reg_idx, logic [CMD_W-1:0] value);
			if (reg_idx == REG_DESCENT_CODE)
				slow_code = value;
			else
				normal_code = value;
		endfunction

		// Slow code applies only when downhill and turning right as the flags stand now
		function logic [CMD_W-1:0] with_speed(logic [CMD_W-1:0] base, logic downhill);
			return base + ((downhill && turn_right) ? slow_code : normal_code);
		endfunction

		function logic [CMD_W-1:0] steer(frame_t f);
			logic [CMD_W-1:0] held;
			logic [CMD_W-1:0] dir_step;
			int unsigned quot;
			bit any_line;
			held = f.previous_command;
			quot = f.direction / 20;
			dir_step = quot[CMD_W-1:0];
			any_line = f.left_line_seen || f.right_line_seen;
			if (f.departed_left) begin
				going = 1'b0;
				turn_right = 1'b1;
				return with_speed(BASE_RIGHT, f.downhill_seen);
			end
			if (f.departed_right) begin
				going = 1'b0;
				turn_left = 1'b1;
				return with_speed(BASE_LEFT, f.downhill_seen);
			end
			if (going) begin
				if (!f.forward_path && (f.right_turn_seen || f.left_turn_seen)) begin
					going = 1'b0;
					curve = 1'b1;
					return held;
				end
				if (!(turn_right || turn_left))
					return with_speed(dir_step, f.downhill_seen);
			end
			// Turning right may fall through to the later rules with bit 7 forced
			if (turn_right) begin
				if (!any_line) begin
					turn_left = 1'b0;
					turn_right = 1'b0;
					going = 1'b1;
					return held;
				end
				if (f.downhill_seen && f.downhill_confirm)
					return with_speed(dir_step, f.downhill_seen);
				held = held | CMD_RIGHT_BIT;
			end
			if (turn_left) begin
				if (!any_line) begin
					turn_left = 1'b0;
					turn_right = 1'b0;
					going = 1'b1;
				end
				return held;
			end
			if (curve) begin
				if (f.road_close) begin
					if (f.direction < DIR_CENTER) begin
						curve = 1'b0;
						turn_right = 1'b1;
						return with_speed(BASE_RIGHT, f.downhill_seen);
					end
					if (f.direction > DIR_CENTER) begin
						curve = 1'b0;
						turn_left = 1'b1;
						return with_speed(BASE_LEFT, f.downhill_seen);
					end
					return with_speed(dir_step, f.downhill_seen);
				end
				return with_speed(BASE_STRAIGHT, f.downhill_seen);
			end
			return held;
		endfunction

		function void note_frame(frame_t f);
			result_t r;
			r.command = steer(f);
			r.mode_going = going;
			r.mode_left = turn_left;
			r.mode_right = turn_right;
			r.mode_curve = curve;
			pending_cmds.push_back(r);
		endfunction

		function void check_field(string label, logic [CMD_W-1:0] want,
			logic [CMD_W-1:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
			end
		endfunction

		function void check_command(result_t r);
			result_t want;
			if (pending_cmds.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: expected none, actual %h",
					$time, r);
				return;
			end
			want = pending_cmds.pop_front();
			check_field("command", want.command, r.command);
			check_field("mode_going", {7'd0, want.mode_going}, {7'd0, r.mode_going});
			check_field("mode_left", {7'd0, want.mode_left}, {7'd0, r.mode_left});
			check_field("mode_right", {7'd0, want.mode_right}, {7'd0, r.mode_right});
			check_field("mode_curve", {7'd0, want.mode_curve}, {7'd0, r.mode_curve});
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	lsmc_frame_if  frame_ch ();
	lsmc_result_if result_ch ();

	steering_scoreboard sb = new();

	bit gappy = 1'b1;
	bit long_hold_req = 1'b0;
	int unsigned cycle_count = 0;

	lane_steering_mode_controller_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.frame   (frame_ch),
		.result  (result_ch)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic frame_t frame_of(logic [DIR_W-1:0] dir, logic [9:0] flags,
		logic [CMD_W-1:0] prev);
		return {dir, flags, prev};
	endfunction

	// Mostly lines kept and turns now and then, so the mode flags walk through
	// curve and turning phases; a slice of pure noise besides
	function automatic frame_t random_frame();
		frame_t f;
		logic [31:0] bits;
		bits = $urandom;
		if ($urandom_range(0, 6) == 0) begin
			f = bits[$bits(frame_t)-1:0];
			return f;
		end
		case ($urandom_range(0, 5))
			0: f.direction = DIR_CENTER;
			1: f.direction = ($urandom_range(0, 1) != 0) ? DIR_CENTER + 12'd1 : DIR_CENTER - 12'd1;
			2, 3: f.direction = 12'($urandom_range(1400, 1600));
			4: f.direction = bits[DIR_W-1:0];
			default: f.direction = ($urandom_range(0, 1) != 0) ? '1 : '0;
		endcase
		f.departed_left = $urandom_range(0, 15) == 0;
		f.departed_right = $urandom_range(0, 15) == 0;
		f.forward_path = $urandom_range(0, 1) != 0;
		f.right_turn_seen = $urandom_range(0, 3) == 0;
		f.left_turn_seen = $urandom_range(0, 3) == 0;
		f.left_line_seen = $urandom_range(0, 9) < 7;
		f.right_line_seen = $urandom_range(0, 9) < 7;
		f.downhill_seen = $urandom_range(0, 1) != 0;
		f.downhill_confirm = $urandom_range(0, 1) != 0;
		f.road_close = $urandom_range(0, 1) != 0;
		f.previous_command = 8'($urandom);
		return f;
	endfunction

	// Call at a rising edge; returns at the edge where the frame is taken
	task automatic send_frame(input frame_t f);
		if (gappy && $urandom_range(0, 4) == 0) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data <= f;
		@(posedge clk);
		while (!frame_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic reg_idx, input logic [CMD_W-1:0] value);
		logic [31:0] upper;
		upper = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {upper[PDATA_W-1:CMD_W], value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_speed(reg_idx, value);
	endtask

	// Let the monitor log the last transaction, wait out every outstanding
	// result, then the pipeline tail
	task automatic settle();
		@(posedge clk);
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_ch.valid && frame_ch.ready)
				sb.note_frame(frame_ch.data);
			if (result_ch.valid && result_ch.ready)
				sb.check_command(result_ch.data);
		end
	end

	// Result side: random stalls, one long hold-off to back up the pipeline
	initial begin
		int unsigned span;
		logic rdy;
		bit hold_done;
		result_ch.ready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				rdy = 1'b0;
				span = LONG_HOLD;
			end else if (gappy && $urandom_range(0, 3) == 0) begin
				rdy = 1'b0;
				span = $urandom_range(1, 19);
			end else begin
				rdy = 1'b1;
				span = $urandom_range(1, 24);
			end
			result_ch.ready <= rdy;
			repeat (span) @(posedge clk);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[lane_steering_mode_controller_top] ERROR");
		$finish;
	end

	initial begin
		logic [CMD_W-1:0] slow_val;
		logic [CMD_W-1:0] normal_val;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame_ch.valid = 1'b0;
		frame_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_DESCENT_CODE, 8'h33);
		write_reg(REG_CRUISE_CODE, 8'hC0);

		// Directed walk through every mode transition
		send_frame(frame_of(12'd0, FL_FWD, 8'hFF));
		send_frame(frame_of(12'hFFF, FL_FWD | FL_DOWN1 | FL_DOWN2, 8'h00));
		send_frame(frame_of(12'd1500, FL_RTURN, 8'h5A));
		send_frame(frame_of(12'd1500, FL_FWD, 8'h00));
		send_frame(frame_of(DIR_CENTER, FL_CLOSE, 8'h00));
		send_frame(frame_of(12'd1499, FL_CLOSE | FL_DOWN1, 8'h00));
		send_frame(frame_of(12'd3000, FL_LLINE | FL_DOWN1 | FL_DOWN2, 8'h01));
		send_frame(frame_of(12'd700, FL_RLINE | FL_DOWN1, 8'h12));
		send_frame(frame_of(12'd700, FL_DOWN2, 8'h34));
		send_frame(frame_of(12'd1500, FL_LTURN, 8'h77));
		send_frame(frame_of(12'd1501, FL_CLOSE, 8'h00));
		send_frame(frame_of(12'd200, FL_LLINE | FL_RLINE, 8'h81));
		send_frame(frame_of(12'd200, '0, 8'h22));
		send_frame(frame_of(12'd1000, FL_DEP_L | FL_DOWN1, 8'h00));
		send_frame(frame_of(12'd1000, FL_DEP_R | FL_DOWN1, 8'h00));
		send_frame(frame_of(12'd4000, FL_LLINE | FL_DOWN1 | FL_DOWN2, 8'h00));
		send_frame(frame_of(12'd4000, FL_RLINE, 8'h55));
		send_frame(frame_of(12'd4000, FL_FWD, 8'h66));
		send_frame(frame_of(12'hFFF, '1, 8'hFF));
		send_frame(frame_of(12'd0, '0, 8'h00));
		send_frame(frame_of(12'd0, FL_RTURN | FL_LTURN, 8'hA5));
		send_frame(frame_of(12'd0, FL_CLOSE | FL_DOWN1 | FL_DOWN2, 8'h3C));
		frame_ch.valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					slow_val = 8'hFF;
					normal_val = 8'hFF;
				end
				1: begin
					slow_val = 8'h00;
					normal_val = 8'h00;
				end
				2: begin
					slow_val = 8'h00;
					normal_val = 8'hFF;
				end
				3: begin
					slow_val = 8'hFF;
					normal_val = 8'h00;
				end
				default: begin
					slow_val = 8'($urandom);
					normal_val = 8'($urandom);
				end
			endcase
			settle();
			write_reg(REG_DESCENT_CODE, slow_val);
			write_reg(REG_CRUISE_CODE, normal_val);
			gappy = (p < PHASES - 1);
			if (p == 1)
				long_hold_req = 1'b1;
			repeat (RANDOM_ITEMS / PHASES) send_frame(random_frame());
			frame_ch.valid <= 1'b0;
		end

		settle();
		if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
			$display("[lane_steering_mode_controller_top] OK");
		else
			$display("[lane_steering_mode_controller_top] ERROR");
		$finish;
	end

endmodule

// ===== lane_steering_mode_controller_top.f =====
+incdir+rtl/core
rtl/core/lsmc_pkg.sv
rtl/core/lsmc_if.sv
rtl/core/lane_steering_mode_controller_top.sv
dv/lane_steering_mode_controller_top_tb.sv
